### rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define XMOE_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define XMOE_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/xmoe_pkg.sv
package xmoe_pkg;

   // Register code ranges
   localparam logic [7:0] NO_REG_MIN  = 8'h80;
   localparam logic [7:0] RIP_CODE    = 8'h20;
   localparam logic [7:0] BAD_INDEX   = 8'h04;

   // ModRM / SIB field codes
   localparam logic [1:0] MOD_NO_DISP = 2'b00;
   localparam logic [1:0] MOD_DISP8   = 2'b01;
   localparam logic [1:0] MOD_DISP32  = 2'b10;
   localparam logic [2:0] RM_SIB      = 3'd4;
   localparam logic [2:0] RM_DISP32   = 3'd5;
   localparam logic [2:0] SIB_NO_IDX  = 3'd4;
   localparam logic [2:0] SIB_NO_BASE = 3'd5;
   localparam logic [1:0] SS_ONE      = 2'd0;

   // Displacement sizes
   localparam logic [2:0] DISP_NONE   = 3'd0;
   localparam logic [2:0] DISP_BYTE   = 3'd1;
   localparam logic [2:0] DISP_DWORD  = 3'd4;

   // RIP-relative: ModRM plus disp32
   localparam logic [31:0] RIP_TAIL   = 32'd5;

   typedef struct packed {
      logic [7:0]         base_code;
      logic [7:0]         index_code;
      logic [7:0]         scale_factor;
      logic signed [31:0] offset;
      logic [2:0]         reg_field;
      logic [3:0]         prefix_len;
      logic [2:0]         disp_shift;
      logic               force_sib;
   } req_type;

   typedef struct packed {
      logic        ok;
      logic [7:0]  modrm_byte;
      logic        has_sib;
      logic [7:0]  sib_byte;
      logic [31:0] disp_value;
      logic [2:0]  disp_bytes;
      logic [4:0]  total_len;
   } rsp_type;

endpackage

### rtl/xmoe_chan_if.sv
interface xmoe_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/xmoe_stage.sv
// One register slot of the pipeline; loads whenever it is empty or being drained.
module xmoe_stage #(
   parameter type payload_type = logic
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        in_valid,
   output logic        in_ready,
   input  payload_type in_payload,
   output logic        out_valid,
   input  logic        out_ready,
   output payload_type out_payload
);
   logic        valid_ff;
   logic        valid_in;
   payload_type data_ff;

   assign in_ready    = !valid_ff || out_ready;
   assign valid_in    = in_ready ? in_valid : valid_ff;
   assign out_valid   = valid_ff;
   assign out_payload = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_payload;
      end
   end
endmodule

### rtl/xmoe_encode.sv
// ModRM / SIB / displacement selection for one operand.
module xmoe_encode (
   input  xmoe_pkg::req_type op,
   output xmoe_pkg::rsp_type enc
);
   logic        idx_absent;
   logic        forced;
   logic [7:0]  eff_index;
   logic [7:0]  eff_scale;
   logic        with_sib;
   logic        scale_pow2;
   logic [1:0]  ss;
   logic [7:0]  sib_part;
   logic        bad_combo;
   logic [31:0] off_u;
   logic [31:0] shifted;
   logic [31:0] low_mask;
   logic        low_zero;
   logic        fits8;
   logic [2:0]  rm;
   logic [1:0]  mod_sel;
   logic [2:0]  dbytes;
   logic [31:0] disp_raw;
   logic        sib_out;
   logic [4:0]  plen_ext;
   xmoe_pkg::rsp_type res;

   assign off_u    = op.offset;
   assign shifted  = $unsigned(op.offset >>> op.disp_shift);
   assign low_mask = ~(32'hFFFF_FFFF << op.disp_shift);
   assign low_zero = (off_u & low_mask) == 32'd0;
   assign fits8    = (shifted[31:7] == '0) || (shifted[31:7] == '1);
   assign rm       = op.base_code[2:0];
   assign plen_ext = {1'b0, op.prefix_len};

   always_comb begin
      idx_absent = op.index_code[7];
      forced     = op.force_sib && idx_absent;
      eff_index  = forced ? {5'd0, xmoe_pkg::SIB_NO_IDX} : op.index_code;
      eff_scale  = forced ? 8'd1 : op.scale_factor;
      with_sib   = !eff_index[7];
      scale_pow2 = (eff_scale == 8'd1) || (eff_scale == 8'd2) ||
                   (eff_scale == 8'd4) || (eff_scale == 8'd8);
      ss         = {eff_scale[3] | eff_scale[2], eff_scale[3] | eff_scale[1]};
      sib_part   = with_sib ? {ss, eff_index[2:0], 3'd0}
                            : {xmoe_pkg::SS_ONE, xmoe_pkg::SIB_NO_IDX, 3'd0};
      bad_combo  = (op.index_code == xmoe_pkg::BAD_INDEX) ||
                   (with_sib && !scale_pow2) ||
                   (!with_sib && (eff_scale != 8'd0));

      res      = '0;
      mod_sel  = xmoe_pkg::MOD_NO_DISP;
      dbytes   = xmoe_pkg::DISP_NONE;
      disp_raw = off_u;
      sib_out  = 1'b0;

      if (op.base_code >= xmoe_pkg::NO_REG_MIN) begin
         // No base: SIB with base 5 and disp32
         res.modrm_byte = {xmoe_pkg::MOD_NO_DISP, op.reg_field, xmoe_pkg::RM_SIB};
         res.sib_byte   = sib_part | {5'd0, xmoe_pkg::SIB_NO_BASE};
         sib_out        = 1'b1;
         dbytes         = xmoe_pkg::DISP_DWORD;
      end else if (op.base_code == xmoe_pkg::RIP_CODE) begin
         bad_combo      = bad_combo || with_sib;
         res.modrm_byte = {xmoe_pkg::MOD_NO_DISP, op.reg_field, xmoe_pkg::RM_DISP32};
         disp_raw       = off_u - {28'd0, op.prefix_len} - xmoe_pkg::RIP_TAIL;
         dbytes         = xmoe_pkg::DISP_DWORD;
      end else if (op.base_code > xmoe_pkg::RIP_CODE) begin
         bad_combo = 1'b1;
      end else begin
         if (off_u != 32'd0) begin
            if (low_zero && fits8) begin
               mod_sel  = xmoe_pkg::MOD_DISP8;
               dbytes   = xmoe_pkg::DISP_BYTE;
               disp_raw = shifted;
            end else begin
               mod_sel = xmoe_pkg::MOD_DISP32;
               dbytes  = xmoe_pkg::DISP_DWORD;
            end
         end else if (rm == xmoe_pkg::RM_DISP32) begin
            // rbp/r13 base needs an explicit zero disp8
            mod_sel = xmoe_pkg::MOD_DISP8;
            dbytes  = xmoe_pkg::DISP_BYTE;
         end
         if (with_sib || rm == xmoe_pkg::RM_SIB) begin
            res.modrm_byte = {mod_sel, op.reg_field, xmoe_pkg::RM_SIB};
            res.sib_byte   = sib_part | {5'd0, rm};
            sib_out        = 1'b1;
         end else begin
            res.modrm_byte = {mod_sel, op.reg_field, rm};
         end
      end

      res.ok         = 1'b1;
      res.has_sib    = sib_out;
      res.disp_bytes = dbytes;
      unique case (dbytes)
         xmoe_pkg::DISP_BYTE:  res.disp_value = {24'd0, disp_raw[7:0]};
         xmoe_pkg::DISP_DWORD: res.disp_value = disp_raw;
         default:              res.disp_value = 32'd0;
      endcase
      res.total_len = plen_ext + 5'd1 + {4'd0, sib_out} + {2'd0, dbytes};

      enc = bad_combo ? '0 : res;
   end
endmodule

### rtl/x86_memory_operand_encoder_top.sv
// Request register -> combinational encoder (single pass) -> result register.
// Throughput: one operand per cycle while the response side keeps taking beats.
// A full result register still takes a new request beat when the response side drains.
// Reset: synchronous, active high; clears both valid flags, payload registers are not reset.
module x86_memory_operand_encoder_top (
   input logic clock,
   input logic reset,
   xmoe_chan_if.sink   req_chan,
   xmoe_chan_if.source rsp_chan
);
   // Request register -> encoder -> result register
   logic              op_valid;
   logic              op_ready;
   xmoe_pkg::req_type op_data;
   xmoe_pkg::rsp_type enc_data;

   // Request register: captures each request beat, releases it when the result slot frees
   xmoe_stage #(
      .payload_type (xmoe_pkg::req_type)
   ) u_req_stage (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_chan.valid),
      .in_ready    (req_chan.ready),
      .in_payload  (req_chan.payload),
      .out_valid   (op_valid),
      .out_ready   (op_ready),
      .out_payload (op_data)
   );

   // ModRM, SIB and displacement choice; all-zero result on an illegal operand
   xmoe_encode u_encode (
      .op  (op_data),
      .enc (enc_data)
   );

   // Result register: holds the response beat until the sink takes it
   xmoe_stage #(
      .payload_type (xmoe_pkg::rsp_type)
   ) u_rsp_stage (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (op_valid),
      .in_ready    (op_ready),
      .in_payload  (enc_data),
      .out_valid   (rsp_chan.valid),
      .out_ready   (rsp_chan.ready),
      .out_payload (rsp_chan.payload)
   );
endmodule

### rtl/xmoe_checker.sv
`include "assert_macros.svh"

module xmoe_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input xmoe_pkg::rsp_type rsp_payload
);
   `XMOE_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload), "stalled response beat changed")
   `XMOE_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "response valid after reset")
   `XMOE_ASSERT(a_err_zero, clock, reset, rsp_valid && !rsp_payload.ok |-> rsp_payload == '0, "error response not all zero")
   `XMOE_ASSERT(a_disp_form, clock, reset, rsp_valid && rsp_payload.ok |-> (rsp_payload.disp_bytes == xmoe_pkg::DISP_BYTE && rsp_payload.disp_value[31:8] == 24'd0) || rsp_payload.disp_bytes == xmoe_pkg::DISP_DWORD || (rsp_payload.disp_bytes == xmoe_pkg::DISP_NONE && rsp_payload.disp_value == 32'd0), "bad displacement form")
   `XMOE_ASSERT(a_latency, clock, reset, (req_valid && req_ready) ##1 rsp_ready |=> rsp_valid, "response beat missing two cycles after request")
endmodule

bind x86_memory_operand_encoder_top xmoe_checker u_xmoe_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);

### tb/x86_memory_operand_encoder_top_test.sv
module x86_memory_operand_encoder_top_test;

   // Watchdog: cycles with no beat on either channel before the run is abandoned.
   // The longest legal quiet stretch comes from the long response hold-off.
   localparam int unsigned STALL_LIMIT  = 1000;
   localparam int unsigned HOLD_CYCLES  = 80;
   localparam int unsigned SETTLE       = 10;
   localparam int unsigned RANDOM_BEATS = 1500;

   // Operand codes used to build stimulus
   localparam logic [7:0] NO_INDEX  = 8'hFF;
   localparam logic [7:0] NO_BASE   = 8'h80;
   localparam logic [7:0] BAD_BASE  = 8'h21;

   // Receiver stall patterns
   typedef enum logic [1:0] {
      TAKE_ALL,
      TAKE_COIN,
      TAKE_TWO_IN_THREE,
      TAKE_LONG_RUNS
   } stall_pattern_type;

   typedef struct {
      xmoe_pkg::req_type beat;
      logic              drain_first;   // hold this beat back until every result is in
   } queued_operand_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   xmoe_chan_if #(.payload_type(xmoe_pkg::req_type)) req_if ();
   xmoe_chan_if #(.payload_type(xmoe_pkg::rsp_type)) rsp_if ();

   x86_memory_operand_encoder_top DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   queued_operand_type operand_queue[$];
   xmoe_pkg::rsp_type  awaited_encodings[$];
   int unsigned        mismatch_count = 0;
   int unsigned        operands_taken = 0;
   int unsigned        stall_cycles   = 0;
   logic               req_took       = 1'b0;
   logic               rsp_hold       = 1'b0;
   int unsigned        burst_left     = 1;
   int unsigned        gap_left       = 0;
   stall_pattern_type  stall_pattern  = TAKE_ALL;
   int unsigned        pattern_left   = 0;
   logic [7:0]         pattern_phase  = '0;
   logic               take_now;

   // ------------------------------------------------------------------
   // Predictor: encode one memory operand into ModRM / SIB / displacement
   // ------------------------------------------------------------------
   function automatic xmoe_pkg::rsp_type encode_operand(input xmoe_pkg::req_type r);
      xmoe_pkg::rsp_type e;
      logic [7:0]  idx;
      logic [7:0]  scl;
      logic        with_idx;
      logic [1:0]  sib_ss;
      logic [2:0]  sib_idx;
      logic [2:0]  sib_base;
      logic        sib_used;
      logic [1:0]  md;
      logic [2:0]  rm;
      logic [2:0]  base_rm;
      logic [31:0] disp;
      logic [31:0] shifted;
      logic [2:0]  nbytes;
      e        = '0;
      idx      = r.index_code;
      scl      = r.scale_factor;
      sib_ss   = xmoe_pkg::SS_ONE;
      sib_idx  = xmoe_pkg::SIB_NO_IDX;
      sib_base = '0;
      sib_used = 1'b0;
      md       = xmoe_pkg::MOD_NO_DISP;
      rm       = '0;
      disp     = r.offset;
      nbytes   = xmoe_pkg::DISP_NONE;

      // code 4 as an index means "no index" in the SIB byte, so it cannot be asked for
      if (idx == xmoe_pkg::BAD_INDEX)
         return e;
      // forced SIB: absent index becomes the "no index" encoding, scale field ignored
      if (r.force_sib && idx >= xmoe_pkg::NO_REG_MIN) begin
         idx = {5'd0, xmoe_pkg::SIB_NO_IDX};
         scl = 8'd1;
      end
      with_idx = (idx < xmoe_pkg::NO_REG_MIN);
      if (with_idx) begin
         case (scl)
            8'd1:    sib_ss = 2'd0;
            8'd2:    sib_ss = 2'd1;
            8'd4:    sib_ss = 2'd2;
            8'd8:    sib_ss = 2'd3;
            default: return e;
         endcase
         sib_idx = idx[2:0];
      end else if (scl != 8'd0) begin
         return e;
      end

      if (r.base_code >= xmoe_pkg::NO_REG_MIN) begin
         // no base: SIB with base 5 under mod 0, always disp32
         rm       = xmoe_pkg::RM_SIB;
         sib_used = 1'b1;
         sib_base = xmoe_pkg::SIB_NO_BASE;
         nbytes   = xmoe_pkg::DISP_DWORD;
      end else if (r.base_code == xmoe_pkg::RIP_CODE) begin
         // RIP-relative cannot carry a SIB byte; offset taken from end of instruction
         if (with_idx)
            return e;
         rm     = xmoe_pkg::RM_DISP32;
         disp   = r.offset - 32'(r.prefix_len) - xmoe_pkg::RIP_TAIL;
         nbytes = xmoe_pkg::DISP_DWORD;
      end else if (r.base_code > xmoe_pkg::RIP_CODE) begin
         return e;
      end else begin
         base_rm = r.base_code[2:0];
         if (r.offset != 32'd0) begin
            shifted = $signed(r.offset) >>> r.disp_shift;
            if ((r.offset & ((32'd1 << r.disp_shift) - 32'd1)) == 32'd0 &&
                shifted[31:7] == {25{shifted[7]}}) begin
               disp   = shifted;
               md     = xmoe_pkg::MOD_DISP8;
               nbytes = xmoe_pkg::DISP_BYTE;
            end else begin
               md     = xmoe_pkg::MOD_DISP32;
               nbytes = xmoe_pkg::DISP_DWORD;
            end
         end else if (base_rm == xmoe_pkg::RM_DISP32) begin
            // rbp/r13 with mod 0 means disp32 only, so a zero disp8 is needed
            md     = xmoe_pkg::MOD_DISP8;
            nbytes = xmoe_pkg::DISP_BYTE;
         end
         if (with_idx || base_rm == xmoe_pkg::RM_SIB) begin
            rm       = xmoe_pkg::RM_SIB;
            sib_used = 1'b1;
            sib_base = base_rm;
         end else begin
            rm = base_rm;
         end
      end

      if (nbytes == xmoe_pkg::DISP_NONE)
         disp = '0;
      else if (nbytes == xmoe_pkg::DISP_BYTE)
         disp = {24'd0, disp[7:0]};

      e.ok         = 1'b1;
      e.modrm_byte = {md, r.reg_field, rm};
      e.has_sib    = sib_used;
      e.sib_byte   = sib_used ? {sib_ss, sib_idx, sib_base} : 8'd0;
      e.disp_value = disp;
      e.disp_bytes = nbytes;
      e.total_len  = 5'(r.prefix_len) + 5'd1 + 5'(sib_used) + 5'(nbytes);
      return e;
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------
   function automatic xmoe_pkg::req_type mem_operand(input logic [7:0] base,
                                                     input logic [7:0] idx,
                                                     input logic [7:0] scl,
                                                     input logic [31:0] off,
                                                     input logic [2:0] rf,
                                                     input logic [3:0] plen,
                                                     input logic [2:0] sh, input logic fs);
      xmoe_pkg::req_type r;
      r.base_code    = base;
      r.index_code   = idx;
      r.scale_factor = scl;
      r.offset       = off;
      r.reg_field    = rf;
      r.prefix_len   = plen;
      r.disp_shift   = sh;
      r.force_sib    = fs;
      return r;
   endfunction

   // Mostly well-formed operands; a minority of bad codes and scales as noise.
   function automatic xmoe_pkg::req_type random_operand();
      xmoe_pkg::req_type r;
      int unsigned pick;
      logic [7:0]  b8;
      r.reg_field  = 3'($urandom_range(0, 7));
      r.prefix_len = 4'($urandom_range(0, 15));
      r.disp_shift = 3'($urandom_range(0, 7));
      r.force_sib  = ($urandom_range(0, 3) == 0);

      pick = $urandom_range(0, 99);
      if (pick < 70)      r.base_code = 8'($urandom_range(0, 31));
      else if (pick < 80) r.base_code = xmoe_pkg::RIP_CODE;
      else if (pick < 92) r.base_code = 8'($urandom_range(128, 255));
      else                r.base_code = 8'($urandom_range(33, 127));

      pick = $urandom_range(0, 99);
      if (pick < 3)       r.index_code = xmoe_pkg::BAD_INDEX;
      else if (pick < 50) r.index_code = 8'($urandom_range(0, 127));
      else                r.index_code = 8'($urandom_range(128, 255));

      pick = $urandom_range(0, 99);
      if (r.index_code < xmoe_pkg::NO_REG_MIN)
         r.scale_factor = (pick < 88) ? (8'd1 << $urandom_range(0, 3))
                                      : 8'($urandom_range(0, 255));
      else
         r.scale_factor = (pick < 90) ? 8'd0 : 8'($urandom_range(0, 255));

      // displacement: zero, disp8 range, scaled disp8 near the edge, or anything
      pick = $urandom_range(0, 99);
      b8   = 8'($urandom_range(0, 255));
      if (pick < 20)
         r.offset = '0;
      else if (pick < 50)
         r.offset = {{24{b8[7]}}, b8};
      else if (pick < 75) begin
         r.offset = {{24{b8[7]}}, b8} << r.disp_shift;
         if ($urandom_range(0, 3) == 0)
            r.offset = r.offset + 32'd1;
         else if ($urandom_range(0, 3) == 0)
            r.offset = r.offset + (32'd128 << r.disp_shift);
      end else
         r.offset = $urandom;
      return r;
   endfunction

   task automatic add_operand(input xmoe_pkg::req_type r, input logic drain);
      queued_operand_type q;
      q.beat        = r;
      q.drain_first = drain;
      operand_queue.push_back(q);
   endtask

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
   endtask

   // ------------------------------------------------------------------
   // Request driver: bursts of random length, random gaps, changes on falling edge
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (req_if.valid && !req_took) begin
         // beat still on offer, hold it
      end else if (gap_left > 0 && !rsp_hold) begin
         gap_left--;
         req_if.valid <= 1'b0;
      end else if (operand_queue.size() == 0) begin
         req_if.valid <= 1'b0;
      end else if (operand_queue[0].drain_first && awaited_encodings.size() != 0) begin
         // pause until the block has handed back everything it owes
         req_if.valid <= 1'b0;
      end else begin
         req_if.payload <= operand_queue[0].beat;
         req_if.valid   <= 1'b1;
         void'(operand_queue.pop_front());
         if (burst_left > 1) begin
            burst_left--;
         end else begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         end
      end
   end

   // ------------------------------------------------------------------
   // Response ready: its own stall pattern, switched every so often
   // ------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            stall_pattern = stall_pattern_type'($urandom_range(0, 3));
            pattern_left  = $urandom_range(10, 120);
         end else begin
            pattern_left--;
         end
         pattern_phase++;
         case (stall_pattern)
            TAKE_ALL:          take_now = 1'b1;
            TAKE_COIN:         take_now = ($urandom_range(0, 1) == 1);
            TAKE_TWO_IN_THREE: take_now = (pattern_phase % 3) != 0;
            default:           take_now = pattern_phase[3:0] < 4'd11;
         endcase
         rsp_if.ready <= take_now && !rsp_hold;
      end
   end

   // Long hold-off on the response side while requests keep coming, so the block
   // fills and pushes back on its input.
   initial begin
      wait (operands_taken >= 400);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   // ------------------------------------------------------------------
   // Monitor: sample both channels on the rising edge, check results in order
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      xmoe_pkg::rsp_type got;
      xmoe_pkg::rsp_type want;
      logic              rsp_beat;
      if (reset) begin
         req_took = 1'b0;
      end else begin
         req_took = req_if.valid && req_if.ready;
         rsp_beat = rsp_if.valid && rsp_if.ready;
         if (rsp_beat) begin
            got = rsp_if.payload;
            if (awaited_encodings.size() == 0) begin
               report_mismatch($sformatf("result beat %0h with nothing outstanding", got));
            end else begin
               want = awaited_encodings.pop_front();
               compare_field("ok",         32'(got.ok),         32'(want.ok));
               compare_field("modrm_byte", 32'(got.modrm_byte), 32'(want.modrm_byte));
               compare_field("has_sib",    32'(got.has_sib),    32'(want.has_sib));
               compare_field("sib_byte",   32'(got.sib_byte),   32'(want.sib_byte));
               compare_field("disp_value", got.disp_value,      want.disp_value);
               compare_field("disp_bytes", 32'(got.disp_bytes), 32'(want.disp_bytes));
               compare_field("total_len",  32'(got.total_len),  32'(want.total_len));
            end
         end
         if (req_took) begin
            awaited_encodings.push_back(encode_operand(req_if.payload));
            operands_taken++;
         end
         stall_cycles = (req_took || rsp_beat) ? 0 : stall_cycles + 1;
      end
   end

   // Watchdog on cycles with no beat at all
   initial begin
      wait (stall_cycles >= STALL_LIMIT);
      $display("x86_memory_operand_encoder_top_test NOT OK");
      $finish;
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------
   initial begin
      // directed: field extremes and every special case
      add_operand(mem_operand(8'd0,  xmoe_pkg::NO_REG_MIN, 8'd0, 32'd0,   3'd0, 4'd0,  3'd0,
                              1'b0), 1'b0);
      // rbp-class base with zero offset needs a zero disp8
      add_operand(mem_operand(8'd5,  xmoe_pkg::NO_REG_MIN, 8'd0, 32'd0,   3'd7, 4'd15, 3'd0,
                              1'b0), 1'b0);
      // rsp-class base always needs a SIB byte
      add_operand(mem_operand(8'd4,  xmoe_pkg::NO_REG_MIN, 8'd0, 32'd127, 3'd2, 4'd3,  3'd0,
                              1'b0), 1'b0);
      add_operand(mem_operand(8'd13, xmoe_pkg::NO_REG_MIN, 8'd0, -32'sd128, 3'd1, 4'd1, 3'd0,
                              1'b0), 1'b0);
      add_operand(mem_operand(8'd31, NO_INDEX,   8'd0, 32'd128, 3'd5, 4'd2,  3'd0, 1'b0), 1'b0);
      add_operand(mem_operand(8'd1,  NO_INDEX,   8'd0, 32'h7FFF_FFFF, 3'd6, 4'd0, 3'd0, 1'b0),
                  1'b0);
      add_operand(mem_operand(8'd2,  NO_INDEX,   8'd0, 32'h8000_0000, 3'd3, 4'd4, 3'd7, 1'b0),
                  1'b0);
      // compressed disp8: aligned and in range, unaligned, aligned but too large
      add_operand(mem_operand(8'd3,  xmoe_pkg::NO_REG_MIN, 8'd0, 32'd1016, 3'd0, 4'd0, 3'd3,
                              1'b0), 1'b0);
      add_operand(mem_operand(8'd3,  xmoe_pkg::NO_REG_MIN, 8'd0, 32'd1017, 3'd0, 4'd0, 3'd3,
                              1'b0), 1'b0);
      add_operand(mem_operand(8'd6,  xmoe_pkg::NO_REG_MIN, 8'd0, -32'sd16384, 3'd4, 4'd9, 3'd7,
                              1'b0), 1'b0);
      add_operand(mem_operand(8'd6,  xmoe_pkg::NO_REG_MIN, 8'd0, 32'd16384, 3'd4, 4'd9, 3'd7,
                              1'b0), 1'b0);
      // every valid scale with an index
      add_operand(mem_operand(8'd0,  8'd0,   8'd1, 32'd8,  3'd1, 4'd0, 3'd0, 1'b0), 1'b0);
      add_operand(mem_operand(8'd7,  8'd15,  8'd2, 32'd0,  3'd2, 4'd5, 3'd0, 1'b0), 1'b0);
      add_operand(mem_operand(8'd9,  8'd127, 8'd4, 32'd64, 3'd3, 4'd7, 3'd1, 1'b0), 1'b0);
      add_operand(mem_operand(8'd10, 8'd12,  8'd8, 32'd0,  3'd4, 4'd8, 3'd0, 1'b0), 1'b0);
      // bad scales and the forbidden index
      add_operand(mem_operand(8'd0,  8'd3, 8'd3, 32'd0, 3'd0, 4'd0, 3'd0, 1'b0), 1'b0);
      add_operand(mem_operand(8'd0,  8'd3, 8'd0, 32'd0, 3'd0, 4'd0, 3'd0, 1'b0), 1'b0);
      add_operand(mem_operand(8'd0,  xmoe_pkg::NO_REG_MIN, 8'd2, 32'd0, 3'd0, 4'd0, 3'd0, 1'b0),
                  1'b0);
      add_operand(mem_operand(8'd0,  xmoe_pkg::BAD_INDEX,  8'd1, 32'd0, 3'd0, 4'd0, 3'd0, 1'b0),
                  1'b0);
      // forced SIB ignores the scale; no effect when an index is present
      add_operand(mem_operand(8'd0,  NO_INDEX,   8'd200, 32'd0, 3'd7, 4'd1, 3'd0, 1'b1), 1'b0);
      add_operand(mem_operand(8'd0,  8'd5,       8'd4,   32'd0, 3'd7, 4'd1, 3'd0, 1'b1), 1'b0);
      // no base, with and without index
      add_operand(mem_operand(NO_BASE, xmoe_pkg::NO_REG_MIN, 8'd0, 32'hFFFF_FFFF, 3'd2, 4'd6,
                              3'd0, 1'b0), 1'b0);
      add_operand(mem_operand(8'hFF, 8'd20, 8'd8, 32'd1, 3'd5, 4'd15, 3'd7, 1'b0), 1'b0);
      // RIP-relative: wrap-around, then with index and with forced SIB (both rejected)
      add_operand(mem_operand(xmoe_pkg::RIP_CODE, NO_INDEX, 8'd0, 32'h8000_0000, 3'd1, 4'd15,
                              3'd0, 1'b0), 1'b0);
      add_operand(mem_operand(xmoe_pkg::RIP_CODE, 8'd1, 8'd1, 32'd0, 3'd1, 4'd0, 3'd0, 1'b0),
                  1'b0);
      add_operand(mem_operand(xmoe_pkg::RIP_CODE, NO_INDEX, 8'd0, 32'd0, 3'd1, 4'd0, 3'd0,
                              1'b1), 1'b0);
      // base codes between RIP and "no base"
      add_operand(mem_operand(BAD_BASE, xmoe_pkg::NO_REG_MIN, 8'd0, 32'd0, 3'd0, 4'd0, 3'd0,
                              1'b0), 1'b0);
      add_operand(mem_operand(8'd127,   xmoe_pkg::NO_REG_MIN, 8'd0, 32'd0, 3'd0, 4'd0, 3'd0,
                              1'b0), 1'b0);

      // random part; one forced drain midway, a few more scattered
      for (int n = 0; n < RANDOM_BEATS; n++)
         add_operand(random_operand(), n == RANDOM_BEATS / 2 || $urandom_range(0, 199) == 0);

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      wait (operand_queue.size() == 0);
      @(negedge clock);
      while (req_if.valid || awaited_encodings.size() != 0)
         @(negedge clock);
      // let any stray beat show up before the verdict
      repeat (SETTLE) @(posedge clock);

      if (mismatch_count == 0)
         $display("x86_memory_operand_encoder_top_test OK");
      else
         $display("x86_memory_operand_encoder_top_test NOT OK");
      $finish;
   end

endmodule
